[sv/sacp_pkg.sv]
// Package with shared types and constants for the prefetching set-associative cache.
`timescale 1ns / 1ps
package sacp_pkg;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OFFSET_BITS     = 3'd0,
    REG_INDEX_BITS      = 3'd1,
    REG_WAYS_IN_USE     = 3'd2,
    REG_REPLACE_LRU     = 3'd3,
    REG_PREFETCH_ENABLE = 3'd4,
    REG_PREFETCH_COUNT  = 3'd5
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_VICT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;
endpackage

[sv/sacp_if.sv]
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface sacp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/set_assoc_cache_with_prefetch.sv]
// Top level of the tag-only set-associative cache with next-block prefetch.
//
// Input channel "req" carries data.address and data.is_write; output channel
// "rsp" carries data.hit, data.mem_reads and data.mem_write, one beat per
// request beat, in order. Configuration is written through cfg_we, cfg_index,
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce. Each block lookup reads the whole set from
// the line memory into a registered row (ST_READ) and compares all ways in
// use against it (ST_EVAL). A miss that finds no free way then scans the
// stamps one way per cycle over the ways in use before the write-back. A
// demand miss with prefetch repeats the lookup for each prefetched block.
// ST_DONE then loads the result register and returns to ST_IDLE, so a new
// request is taken only once the previous one is through. The worst case is
// a miss with 15 prefetches in a full 16-way set.
// After reset, a clearing pass over all MAX_SETS sets invalidates every set;
// no request is accepted meanwhile. A stalled result is held in the output
// register; the next request is still accepted and looked up, and its result
// waits in the final state until the register has been taken.
`timescale 1ns / 1ps
module set_assoc_cache_with_prefetch
  import sacp_pkg::*;
#(
  parameter int MAX_SETS     = 256,
  parameter int MAX_WAYS     = 16,
  parameter int ADDR_BITS    = 48,
  parameter int MAX_PREFETCH = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  sacp_if.sink                req,
  sacp_if.source              rsp
);
  localparam int SetW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MaxIb = $clog2(MAX_SETS);
  localparam int WayW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WcntW = $clog2(MAX_WAYS + 1);
  localparam int PfW   = $clog2(MAX_PREFETCH + 1);

  // Configuration registers.
  logic [3:0] offset_bits, index_bits, prefetch_count;
  logic [4:0] ways_in_use;
  logic       replace_lru, prefetch_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd6; index_bits <= 4'd0; ways_in_use <= 5'd1;
      replace_lru <= 1'b0; prefetch_enable <= 1'b0; prefetch_count <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BITS:     offset_bits <= cfg_data[3:0];
        REG_INDEX_BITS:      index_bits <= cfg_data[3:0];
        REG_WAYS_IN_USE:     ways_in_use <= cfg_data[4:0];
        REG_REPLACE_LRU:     replace_lru <= cfg_data[0];
        REG_PREFETCH_ENABLE: prefetch_enable <= cfg_data[0];
        REG_PREFETCH_COUNT:  prefetch_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective geometry.
  logic [3:0]       ib_eff;
  logic [WcntW-1:0] ways_eff;
  logic [PfW-1:0]   pf_eff;
  always_comb begin
    ib_eff = (index_bits > 4'(MaxIb)) ? 4'(MaxIb) : index_bits;
    if (ways_in_use == 5'd0) ways_eff = WcntW'(1);
    else if (32'(ways_in_use) > MAX_WAYS) ways_eff = WcntW'(MAX_WAYS);
    else ways_eff = WcntW'(ways_in_use);
    pf_eff = (32'(prefetch_count) > MAX_PREFETCH) ? PfW'(MAX_PREFETCH)
                                                  : PfW'(prefetch_count);
  end

  // Set memories: one wide word per set holding every way.
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [31:0]          stamp;
  } line_t;
  typedef line_t [MAX_WAYS-1:0] row_t;

  row_t        line_mem [MAX_SETS];
  logic [31:0] stamp_mem [MAX_SETS];
  row_t        row_q;
  logic [31:0] sstamp_q;
  logic [SetW-1:0] rd_set, wr_set;
  logic        mem_we;
  row_t        row_wr;
  logic [31:0] sstamp_wr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_set]  <= row_wr;
      stamp_mem[wr_set] <= sstamp_wr;
    end
    row_q    <= line_mem[rd_set];
    sstamp_q <= stamp_mem[rd_set];
  end

  // Control.
  state_t state;
  logic [SetW:0]          clr_cnt;
  logic [ADDR_BITS-1:0]   addr_base, look_addr;
  logic                   wr_q, hit_q, prefetching;
  logic [PfW-1:0]         pf_k;
  logic [4:0]             reads;
  logic [WayW-1:0]        scan_w, victim;
  logic [31:0]            vstamp;
  logic                   out_valid;
  logic                   out_hit, out_wr;
  logic [4:0]             out_reads;

  // Address split of the current lookup.
  logic [ADDR_BITS-1:0] blk, tag;
  logic [SetW-1:0]      set_idx;
  always_comb begin
    blk     = look_addr >> offset_bits;
    tag     = blk >> ib_eff;
    set_idx = SetW'(blk & ((ADDR_BITS'(1) << ib_eff) - ADDR_BITS'(1)));
  end

  // Way compare over the registered row.
  logic            any_hit, any_inv;
  logic [WayW-1:0] hit_w, inv_w;
  always_comb begin
    any_hit = 1'b0; any_inv = 1'b0; hit_w = '0; inv_w = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < 32'(ways_eff)) begin
        if (row_q[w].valid && row_q[w].tag == tag) begin
          any_hit = 1'b1; hit_w = WayW'(w);
        end
        if (!row_q[w].valid) begin
          any_inv = 1'b1; inv_w = WayW'(w);
        end
      end
    end
  end

  logic [31:0] sstamp_inc;
  assign sstamp_inc = sstamp_q + 32'd1;

  always_comb begin
    rd_set = set_idx; wr_set = set_idx; mem_we = 1'b0;
    row_wr = row_q; sstamp_wr = sstamp_inc;
    if (state == ST_CLEAR) begin
      wr_set = clr_cnt[SetW-1:0]; mem_we = 1'b1; row_wr = '0; sstamp_wr = '0;
    end else if (state == ST_EVAL && any_hit && replace_lru) begin
      mem_we = 1'b1; row_wr[hit_w].stamp = sstamp_inc;
    end else if (state == ST_EVAL && !any_hit && any_inv) begin
      mem_we = 1'b1; row_wr[inv_w] = '{1'b1, tag, sstamp_inc};
    end else if (state == ST_VICT && 32'(scan_w) >= 32'(ways_eff) - 1) begin
      mem_we = 1'b1; row_wr[victim] = '{1'b1, tag, sstamp_inc};
    end
  end

  logic lookup_done, lookup_hit;
  assign lookup_done = (state == ST_EVAL && (any_hit || any_inv)) ||
                       (state == ST_VICT && 32'(scan_w) >= 32'(ways_eff) - 1);
  assign lookup_hit  = (state == ST_EVAL) && any_hit;

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data.hit       = out_hit;
  assign rsp.data.mem_reads = out_reads;
  assign rsp.data.mem_write = out_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR; clr_cnt <= '0; out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == MAX_SETS - 1) state <= ST_IDLE;
        end
        ST_IDLE: if (req.valid && req.ready) begin
          addr_base <= req.data.address; look_addr <= req.data.address;
          wr_q <= req.data.is_write; prefetching <= 1'b0;
          pf_k <= '0; reads <= '0; state <= ST_READ;
        end
        ST_READ: state <= ST_EVAL;
        ST_EVAL: begin
          // Victim scan starts with way 0 as the running minimum.
          victim <= '0; vstamp <= row_q[0].stamp; scan_w <= '0;
          if (!(any_hit || any_inv)) state <= ST_VICT;
        end
        ST_VICT: begin
          if (32'(scan_w) < 32'(ways_eff) - 1) begin
            scan_w <= scan_w + 1'b1;
            if (row_q[scan_w + 1'b1].stamp < vstamp) begin
              victim <= scan_w + 1'b1; vstamp <= row_q[scan_w + 1'b1].stamp;
            end
          end
        end
        ST_DONE: if (!out_valid) begin
          out_valid <= 1'b1; out_hit <= hit_q; out_reads <= reads; out_wr <= wr_q;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (lookup_done) begin
        logic [4:0] r;
        logic       more;
        r = reads + {4'd0, !lookup_hit};
        reads <= r;
        if (!prefetching) hit_q <= lookup_hit;
        more = prefetching ? (pf_k < pf_eff)
                           : (!lookup_hit && prefetch_enable && pf_eff != '0);
        if (more) begin
          prefetching <= 1'b1;
          pf_k <= pf_k + 1'b1;
          look_addr <= addr_base +
                       (ADDR_BITS'(pf_k + 1'b1) << offset_bits);
          state <= ST_READ;
        end else begin
          state <= ST_DONE;
        end
      end
    end
  end
endmodule
